[rtl/rsb_pkg.sv]
// Shared types and constants for the rotated sprite blit core.
// Holds the register map, command codes, color keys and the config struct.
// No dependencies; every other file imports this package.
package rsb_pkg;

  localparam int COLOR_W    = 32;
  localparam int LOAD_W     = 6;
  localparam int Q_FRAC     = 14;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // rounding offsets: halves away from zero
  localparam int RND_POS = 1 << (Q_FRAC - 1);
  localparam int RND_NEG = RND_POS - 1;

  localparam logic [COLOR_W-1:0] KEY_BLACK = 32'hff00_0000;
  localparam logic [COLOR_W-1:0] KEY_CLEAR = 32'h0000_0000;

  typedef enum logic [2:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_POS_X  = 3'd2,
    REG_POS_Y  = 3'd3,
    REG_SRC_W  = 3'd4,
    REG_SRC_H  = 3'd5,
    REG_DEST_W = 3'd6,
    REG_DEST_H = 3'd7
  } reg_idx_e;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [15:0] cos_q14;
    logic [15:0] sin_q14;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [6:0]  src_width;
    logic [6:0]  src_height;
    logic [11:0] dest_width;
    logic [11:0] dest_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cos_q14:     16'h4000,
    sin_q14:     16'h0000,
    pos_x:       12'h000,
    pos_y:       12'h000,
    src_width:   7'd64,
    src_height:  7'd64,
    dest_width:  12'h800,
    dest_height: 12'h800
  };

endpackage

[rtl/rotated_sprite_blit_core.sv]
// Rotated sprite blit core: six-stage pipeline with a sprite store and APB config.
// Depends on rsb_pkg, rsb_cfg_regs and rsb_sprite_mem.
//
//  channel   | direction | handshake        | carries
//  ----------+-----------+------------------+------------------------------------
//  s_axis    | in        | tvalid / tready  | load pixel or render coordinate
//  m_axis    | out       | tvalid / tready  | write flag, dest coordinate, color
//  apb       | in        | psel/penable     | rotation, position and size regs
//
// One word is accepted per cycle unless an m_axis stall has filled the pipeline.
// Stages: offset subtract, four multiplies, sums, round and clip, store access, key.
// Loads write the store in the same stage where renders read it, so order is kept.
// Reset clears the valid bits and the config registers; the store needs no clearing pass.
// A stall on m_axis_tready backs up stage by stage; empty stages still fill.
module rotated_sprite_blit_core #(
  parameter int SRC_MAX_DIM = 64,
  parameter int COORD_BITS  = 11,
  localparam int S_TDATA_W  =
    ((2*rsb_pkg::LOAD_W + rsb_pkg::COLOR_W + 2*COORD_BITS + 7) / 8) * 8,
  localparam int M_TDATA_W  = ((2*COORD_BITS + rsb_pkg::COLOR_W + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // load_x, load_y, load_color, dest_x, dest_y (lowest first), zero padded
  input  logic [S_TDATA_W-1:0]            s_axis_tdata,
  // command
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_x, out_y, out_color (lowest first), zero padded
  output logic [M_TDATA_W-1:0]            m_axis_tdata,
  // write_enable
  output logic                            m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rsb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rsb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rsb_pkg::*;

  localparam int SIDX_W = $clog2(SRC_MAX_DIM);
  localparam int MEM_AW = 2 * SIDX_W;
  localparam int SW_W   = $clog2(SRC_MAX_DIM + 1);
  localparam int CX_W   = SW_W - 1;
  localparam int DW     = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
  localparam int PRD_W  = DW + 16;
  localparam int PW     = DW + 17;
  localparam int RW     = PW - Q_FRAC;
  localparam int OFF_DX = 2*LOAD_W + COLOR_W;
  localparam int OFF_DY = OFF_DX + COORD_BITS;

  cfg_t cfg;

  rsb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // source size clamped to the store, and its integer half
  logic [SW_W-1:0] sw, sh;
  logic [CX_W-1:0] cx, cy;

  always_comb begin
    sw = (32'(cfg.src_width) > SRC_MAX_DIM) ? SW_W'(SRC_MAX_DIM) : SW_W'(cfg.src_width);
    sh = (32'(cfg.src_height) > SRC_MAX_DIM) ? SW_W'(SRC_MAX_DIM) : SW_W'(cfg.src_height);
    cx = sw[SW_W-1:1];
    cy = sh[SW_W-1:1];
  end

  // stage enables: a stage loads when empty or when the next one loads
  logic en1, en2, en3, en4, en5, en6;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  assign en6 = !v6_q || m_axis_tready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // input unpack
  cmd_e                  in_cmd;
  logic [LOAD_W-1:0]     in_lx, in_ly;
  logic [COLOR_W-1:0]    in_col;
  logic [COORD_BITS-1:0] in_x, in_y;

  assign in_cmd = cmd_e'(s_axis_tuser);
  assign in_lx  = s_axis_tdata[LOAD_W-1:0];
  assign in_ly  = s_axis_tdata[2*LOAD_W-1:LOAD_W];
  assign in_col = s_axis_tdata[OFF_DX-1:2*LOAD_W];
  assign in_x   = s_axis_tdata[OFF_DY-1:OFF_DX];
  assign in_y   = s_axis_tdata[OFF_DY+COORD_BITS-1:OFF_DY];

  // ---------------- stage 1: offset from rotation center
  logic                  rnd1_q, ok1_q, ok1_d;
  logic [SIDX_W-1:0]     lx1_q, ly1_q;
  logic [COLOR_W-1:0]    col1_q;
  logic [COORD_BITS-1:0] x1_q, y1_q;
  logic signed [DW-1:0]  dx1_q, dy1_q, dx1_d, dy1_d;

  always_comb begin
    dx1_d = DW'(in_x) - DW'($signed(cfg.pos_x)) - DW'(cx);
    dy1_d = DW'(in_y) - DW'($signed(cfg.pos_y)) - DW'(cy);
    if (in_cmd == CMD_RENDER) begin
      ok1_d = (32'(in_x) < 32'(cfg.dest_width)) && (32'(in_y) < 32'(cfg.dest_height));
    end else begin
      ok1_d = (32'(in_lx) < SRC_MAX_DIM) && (32'(in_ly) < SRC_MAX_DIM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      rnd1_q <= (in_cmd == CMD_RENDER);
      ok1_q  <= ok1_d;
      lx1_q  <= SIDX_W'(in_lx);
      ly1_q  <= SIDX_W'(in_ly);
      col1_q <= in_col;
      x1_q   <= in_x;
      y1_q   <= in_y;
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
    end
  end

  // ---------------- stage 2: products
  logic                    rnd2_q, ok2_q;
  logic [SIDX_W-1:0]       lx2_q, ly2_q;
  logic [COLOR_W-1:0]      col2_q;
  logic [COORD_BITS-1:0]   x2_q, y2_q;
  logic signed [15:0]      cos_s, sin_s;
  logic signed [PRD_W-1:0] pxc2_q, pys2_q, pxs2_q, pyc2_q;

  assign cos_s = $signed(cfg.cos_q14);
  assign sin_s = $signed(cfg.sin_q14);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      rnd2_q <= rnd1_q;
      ok2_q  <= ok1_q;
      lx2_q  <= lx1_q;
      ly2_q  <= ly1_q;
      col2_q <= col1_q;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      pxc2_q <= dx1_q * cos_s;
      pys2_q <= dy1_q * sin_s;
      pxs2_q <= dx1_q * sin_s;
      pyc2_q <= dy1_q * cos_s;
    end
  end

  // ---------------- stage 3: rotated sums plus source center
  logic                  rnd3_q, ok3_q;
  logic [SIDX_W-1:0]     lx3_q, ly3_q;
  logic [COLOR_W-1:0]    col3_q;
  logic [COORD_BITS-1:0] x3_q, y3_q;
  logic signed [PW-1:0]  sumx3_q, sumy3_q, sumx3_d, sumy3_d;

  always_comb begin
    sumx3_d = PW'(pxc2_q) - PW'(pys2_q) + (PW'(cx) << Q_FRAC);
    sumy3_d = PW'(pxs2_q) + PW'(pyc2_q) + (PW'(cy) << Q_FRAC);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      rnd3_q  <= rnd2_q;
      ok3_q   <= ok2_q;
      lx3_q   <= lx2_q;
      ly3_q   <= ly2_q;
      col3_q  <= col2_q;
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      sumx3_q <= sumx3_d;
      sumy3_q <= sumy3_d;
    end
  end

  // ---------------- stage 4: round, clip, form store address
  logic                  rnd4_q, act4_q, act4_d;
  logic [MEM_AW-1:0]     addr4_q, addr4_d;
  logic [COLOR_W-1:0]    col4_q;
  logic [COORD_BITS-1:0] x4_q, y4_q;
  logic signed [PW-1:0]  rndx, rndy;
  logic [RW-1:0]         sx, sy;
  logic                  hit;

  always_comb begin
    rndx = sumx3_q + (sumx3_q[PW-1] ? PW'(RND_NEG) : PW'(RND_POS));
    rndy = sumy3_q + (sumy3_q[PW-1] ? PW'(RND_NEG) : PW'(RND_POS));
    sx   = rndx[PW-1:Q_FRAC];
    sy   = rndy[PW-1:Q_FRAC];
    hit  = !sx[RW-1] && (sx < RW'(sw)) && !sy[RW-1] && (sy < RW'(sh));
    if (rnd3_q) begin
      act4_d  = ok3_q && hit;
      addr4_d = {sy[SIDX_W-1:0], sx[SIDX_W-1:0]};
    end else begin
      act4_d  = ok3_q;
      addr4_d = {ly3_q, lx3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      rnd4_q  <= rnd3_q;
      act4_q  <= act4_d;
      addr4_q <= addr4_d;
      col4_q  <= col3_q;
      x4_q    <= x3_q;
      y4_q    <= y3_q;
    end
  end

  // ---------------- stage 5: store access
  logic                  rnd5_q, act5_q;
  logic [COORD_BITS-1:0] x5_q, y5_q;
  logic [COLOR_W-1:0]    rdata;
  logic                  mem_we, mem_re;

  assign mem_we = en5 && v4_q && !rnd4_q && act4_q;
  assign mem_re = en5 && v4_q && rnd4_q;

  rsb_sprite_mem #(
    .ADDR_W (MEM_AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (addr4_q),
    .wdata_i (col4_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (en5) begin
      rnd5_q <= rnd4_q;
      act5_q <= act4_q;
      x5_q   <= x4_q;
      y5_q   <= y4_q;
    end
  end

  // ---------------- stage 6: color key and output register
  logic                  we6_q, we6_d;
  logic [COLOR_W-1:0]    oc6_q, oc6_d;
  logic [COORD_BITS-1:0] ox6_q, oy6_q, ox6_d, oy6_d;

  always_comb begin
    we6_d = rnd5_q && act5_q && (rdata != KEY_BLACK) && (rdata != KEY_CLEAR);
    oc6_d = we6_d ? rdata : '0;
    ox6_d = rnd5_q ? x5_q : '0;
    oy6_d = rnd5_q ? y5_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      we6_q <= we6_d;
      oc6_q <= oc6_d;
      ox6_q <= ox6_d;
      oy6_q <= oy6_d;
    end
  end

  assign m_axis_tvalid = v6_q;
  assign m_axis_tuser  = we6_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[COORD_BITS-1:0]                          = ox6_q;
    m_axis_tdata[2*COORD_BITS-1:COORD_BITS]               = oy6_q;
    m_axis_tdata[2*COORD_BITS+COLOR_W-1:2*COORD_BITS]     = oc6_q;
  end

endmodule

[rtl/rsb_cfg_regs.sv]
// APB register file for the rotated sprite blit core.
// Depends on rsb_pkg for the register map and the cfg_t struct.
module rsb_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rsb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rsb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rsb_pkg::cfg_t                   cfg_o
);
  import rsb_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_COS:    cfg_d.cos_q14     = pwdata[15:0];
        REG_SIN:    cfg_d.sin_q14     = pwdata[15:0];
        REG_POS_X:  cfg_d.pos_x       = pwdata[11:0];
        REG_POS_Y:  cfg_d.pos_y       = pwdata[11:0];
        REG_SRC_W:  cfg_d.src_width   = pwdata[6:0];
        REG_SRC_H:  cfg_d.src_height  = pwdata[6:0];
        REG_DEST_W: cfg_d.dest_width  = pwdata[11:0];
        REG_DEST_H: cfg_d.dest_height = pwdata[11:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COS:    prdata = CFG_DATA_W'(cfg_q.cos_q14);
      REG_SIN:    prdata = CFG_DATA_W'(cfg_q.sin_q14);
      REG_POS_X:  prdata = CFG_DATA_W'(cfg_q.pos_x);
      REG_POS_Y:  prdata = CFG_DATA_W'(cfg_q.pos_y);
      REG_SRC_W:  prdata = CFG_DATA_W'(cfg_q.src_width);
      REG_SRC_H:  prdata = CFG_DATA_W'(cfg_q.src_height);
      REG_DEST_W: prdata = CFG_DATA_W'(cfg_q.dest_width);
      REG_DEST_H: prdata = CFG_DATA_W'(cfg_q.dest_height);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/rsb_sprite_mem.sv]
// Single-port sprite store: one write or one read per cycle, registered read.
// Depends on rsb_pkg for the color width.
module rsb_sprite_mem #(
  parameter int ADDR_W = 12
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           addr_i,
  input  logic [rsb_pkg::COLOR_W-1:0] wdata_i,
  output logic [rsb_pkg::COLOR_W-1:0] rdata_o
);
  import rsb_pkg::*;

  logic [COLOR_W-1:0] mem_q [2**ADDR_W];
  logic [COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // hold read data while the consuming stage stalls
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rsb_checker.sv]
// Port-level checks for the rotated sprite blit core, bound to the top level.
// Depends on rsb_pkg and on rotated_sprite_blit_core's port list.
module rsb_checker #(
  parameter int COORD_BITS = 11,
  parameter int M_TDATA_W  = ((2*COORD_BITS + rsb_pkg::COLOR_W + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);
  import rsb_pkg::*;

  logic [COLOR_W-1:0] out_color;

  assign out_color = m_axis_tdata[2*COORD_BITS+COLOR_W-1:2*COORD_BITS];

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // an empty output register never blocks the input side
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // keyed colors never produce a write
  a_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (out_color != KEY_BLACK) && (out_color != KEY_CLEAR))
    else $error("write issued with a transparent color");

  // no write means no color
  a_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> out_color == '0)
    else $error("color present without write");

endmodule

bind rotated_sprite_blit_core rsb_checker #(
  .COORD_BITS (COORD_BITS)
) u_rsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/rsb_blit_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for rotated_sprite_blit_core: snoops the APB, s_axis and m_axis channels.
// It predicts each output word in order and compares it field by field. Depends on rsb_pkg.
module rsb_blit_checker #(
  parameter int SRC_MAX_DIM = 64,
  parameter int COORD_BITS  = 11,
  parameter int S_TDATA_W   = 72,
  parameter int M_TDATA_W   = 56
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // load_x, load_y, load_color, dest_x, dest_y (lowest first), zero padded
  input  logic [S_TDATA_W-1:0]           s_axis_tdata,
  // command
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_x, out_y, out_color (lowest first), zero padded
  input  logic [M_TDATA_W-1:0]           m_axis_tdata,
  // write_enable
  input  logic                           m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rsb_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             write_count_o
);
  import rsb_pkg::*;

  localparam int LY_LSB = LOAD_W;
  localparam int LC_LSB = 2 * LOAD_W;
  localparam int PX_LSB = LC_LSB + COLOR_W;
  localparam int PY_LSB = PX_LSB + COORD_BITS;
  localparam int OY_LSB = COORD_BITS;
  localparam int OC_LSB = 2 * COORD_BITS;

  typedef struct packed {
    logic                  write_enable;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_W-1:0]    color;
  } pixel_write_t;

  cfg_t               regs;
  logic [COLOR_W-1:0] sprite_mem [SRC_MAX_DIM*SRC_MAX_DIM];
  pixel_write_t       expected_writes [$];
  int                 fails;
  int                 writes_seen;

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fails++;
    if (fails <= 40)
      $display("%0t: %s: expected %0h, seen %0h", $time, what, want, got);
  endtask

  // halves go away from zero
  function automatic longint round_q14(longint v);
    if (v >= 0) return (v + RND_POS) >>> Q_FRAC;
    return -((-v + RND_POS) >>> Q_FRAC);
  endfunction

  function automatic pixel_write_t predict_pixel(logic [COORD_BITS-1:0] px,
                                                 logic [COORD_BITS-1:0] py);
    pixel_write_t       r;
    longint             sw, sh, ox, oy, c, s, sx, sy;
    logic [COLOR_W-1:0] col;
    sw = (regs.src_width > SRC_MAX_DIM) ? SRC_MAX_DIM : regs.src_width;
    sh = (regs.src_height > SRC_MAX_DIM) ? SRC_MAX_DIM : regs.src_height;
    ox = longint'(px) - (longint'($signed(regs.pos_x)) + sw / 2);
    oy = longint'(py) - (longint'($signed(regs.pos_y)) + sh / 2);
    c  = longint'($signed(regs.cos_q14));
    s  = longint'($signed(regs.sin_q14));
    sx = round_q14(ox * c - oy * s + ((sw / 2) <<< Q_FRAC));
    sy = round_q14(ox * s + oy * c + ((sh / 2) <<< Q_FRAC));
    r   = '0;
    r.x = px;
    r.y = py;
    if (sx >= 0 && sx < sw && sy >= 0 && sy < sh &&
        px < regs.dest_width && py < regs.dest_height) begin
      col = sprite_mem[sy * SRC_MAX_DIM + sx];
      if (col != KEY_BLACK && col != KEY_CLEAR) begin
        r.write_enable = 1'b1;
        r.color        = col;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_write_t want, got;
    logic [LOAD_W-1:0] lx, ly;
    if (!rst_ni) begin
      regs = CFG_RESET;
      expected_writes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_COS:    regs.cos_q14     = pwdata[15:0];
          REG_SIN:    regs.sin_q14     = pwdata[15:0];
          REG_POS_X:  regs.pos_x       = pwdata[11:0];
          REG_POS_Y:  regs.pos_y       = pwdata[11:0];
          REG_SRC_W:  regs.src_width   = pwdata[6:0];
          REG_SRC_H:  regs.src_height  = pwdata[6:0];
          REG_DEST_W: regs.dest_width  = pwdata[11:0];
          REG_DEST_H: regs.dest_height = pwdata[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (cmd_e'(s_axis_tuser) == CMD_LOAD) begin
          lx = s_axis_tdata[0 +: LOAD_W];
          ly = s_axis_tdata[LY_LSB +: LOAD_W];
          if (lx < SRC_MAX_DIM && ly < SRC_MAX_DIM)
            sprite_mem[ly * SRC_MAX_DIM + lx] = s_axis_tdata[LC_LSB +: COLOR_W];
          expected_writes.push_back('0);
        end else begin
          expected_writes.push_back(predict_pixel(s_axis_tdata[PX_LSB +: COORD_BITS],
                                                  s_axis_tdata[PY_LSB +: COORD_BITS]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.write_enable = m_axis_tuser;
        got.x            = m_axis_tdata[0 +: COORD_BITS];
        got.y            = m_axis_tdata[OY_LSB +: COORD_BITS];
        got.color        = m_axis_tdata[OC_LSB +: COLOR_W];
        if (got.write_enable) writes_seen++;
        if (expected_writes.size() == 0) begin
          report_mismatch("output word with nothing pending", '0, got);
        end else begin
          want = expected_writes.pop_front();
          if (got.write_enable !== want.write_enable)
            report_mismatch("write_enable", want.write_enable, got.write_enable);
          if (got.x !== want.x) report_mismatch("out_x", want.x, got.x);
          if (got.y !== want.y) report_mismatch("out_y", want.y, got.y);
          if (got.color !== want.color) report_mismatch("out_color", want.color, got.color);
        end
      end
    end
    fail_count_o  <= fails;
    pending_o     <= expected_writes.size();
    write_count_o <= writes_seen;
  end

endmodule

[tb/sv/rotated_sprite_blit_core_tb.sv]
`timescale 1ns / 1ps
// Top of the rotated_sprite_blit_core testbench: clock, reset, APB settings and pixel traffic.
// Needs rsb_pkg, the core and rsb_blit_checker, which predicts and compares.
module rotated_sprite_blit_core_tb;
  import rsb_pkg::*;

  localparam int SRC_MAX_DIM = 64;
  localparam int COORD_BITS  = 11;
  localparam int S_TDATA_W   = ((2*LOAD_W + COLOR_W + 2*COORD_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((2*COORD_BITS + COLOR_W + 7) / 8) * 8;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int write_count;
  int loads_sent;
  int renders_sent;
  int phases_run;
  bit steady;

  // setting in force and which store words were loaded so far
  cfg_t cur_cfg = CFG_RESET;
  bit   written [SRC_MAX_DIM*SRC_MAX_DIM];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rotated_sprite_blit_core #(
    .SRC_MAX_DIM(SRC_MAX_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rsb_blit_checker #(
    .SRC_MAX_DIM(SRC_MAX_DIM),
    .COORD_BITS (COORD_BITS),
    .S_TDATA_W  (S_TDATA_W),
    .M_TDATA_W  (M_TDATA_W)
  ) u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .write_count_o(write_count)
  );

  // always back to back in a steady phase; else mostly back to back, sometimes a short gap, rarely a long hole
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [COLOR_W-1:0] random_color();
    case ($urandom_range(0, 7))
      0: return KEY_BLACK;
      1: return KEY_CLEAR;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_angle();
    case ($urandom_range(0, 7))
      0: return 16'h4000;
      1: return 16'hc000;
      2: return 16'h0000;
      3: return 16'h2000;
      4: return 16'he000;
      5: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [11:0] random_pos();
    case ($urandom_range(0, 5))
      0: return 12'h800;
      1: return 12'h7ff;
      2: return 12'($urandom);
      default: return 12'($urandom_range(0, 400) - 40);
    endcase
  endfunction

  function automatic logic [6:0] random_src_size();
    case ($urandom_range(0, 11))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(2, 64));
    endcase
  endfunction

  function automatic logic [11:0] random_dest_size();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd2048;
      3: return 12'($urandom);
      default: return 12'($urandom_range(1, 2048));
    endcase
  endfunction

  function automatic cfg_t random_setting();
    cfg_t c;
    c.cos_q14     = random_angle();
    c.sin_q14     = random_angle();
    c.pos_x       = random_pos();
    c.pos_y       = random_pos();
    c.src_width   = random_src_size();
    c.src_height  = random_src_size();
    c.dest_width  = random_dest_size();
    c.dest_height = random_dest_size();
    return c;
  endfunction

  // halves go away from zero
  function automatic longint round_half_away(longint v);
    if (v >= 0) return (v + RND_POS) >>> Q_FRAC;
    return -((-v + RND_POS) >>> Q_FRAC);
  endfunction

  // store word a render would fetch under the current setting, or -1 when none
  function automatic int fetch_index(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    longint sw, sh, ox, oy, c, s, sx, sy;
    sw = (cur_cfg.src_width > SRC_MAX_DIM) ? SRC_MAX_DIM : cur_cfg.src_width;
    sh = (cur_cfg.src_height > SRC_MAX_DIM) ? SRC_MAX_DIM : cur_cfg.src_height;
    ox = longint'(px) - (longint'($signed(cur_cfg.pos_x)) + sw / 2);
    oy = longint'(py) - (longint'($signed(cur_cfg.pos_y)) + sh / 2);
    c  = longint'($signed(cur_cfg.cos_q14));
    s  = longint'($signed(cur_cfg.sin_q14));
    sx = round_half_away(ox * c - oy * s + ((sw / 2) <<< Q_FRAC));
    sy = round_half_away(ox * s + oy * c + ((sh / 2) <<< Q_FRAC));
    if (sx < 0 || sx >= sw || sy < 0 || sy >= sh ||
        px >= cur_cfg.dest_width || py >= cur_cfg.dest_height)
      return -1;
    return int'(sy * SRC_MAX_DIM + sx);
  endfunction

  // valid stays high across back-to-back words; drop it only for a gap
  task automatic send_word(cmd_e cmd, logic [S_TDATA_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // unused fields carry noise; the core must ignore them
  task automatic load_pixel(logic [LOAD_W-1:0] x, logic [LOAD_W-1:0] y,
                            logic [COLOR_W-1:0] color);
    logic [COORD_BITS-1:0] px, py;
    px = COORD_BITS'($urandom);
    py = COORD_BITS'($urandom);
    loads_sent++;
    written[int'(y) * SRC_MAX_DIM + int'(x)] = 1'b1;
    send_word(CMD_LOAD, S_TDATA_W'({py, px, color, y, x}));
  endtask

  task automatic render_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    logic [COLOR_W-1:0] noise;
    int                 idx;
    idx = fetch_index(px, py);
    // load the fetched word first if it was never written
    if (idx >= 0 && !written[idx])
      load_pixel(LOAD_W'(idx % SRC_MAX_DIM), LOAD_W'(idx / SRC_MAX_DIM), random_color());
    noise = $urandom;
    renders_sent++;
    send_word(CMD_RENDER, S_TDATA_W'({py, px, noise, LOAD_W'($urandom), LOAD_W'($urandom)}));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // psel stays high between back-to-back writes; each write has setup and access
  task automatic apply_setting(cfg_t c);
    reg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    for (int i = 0; i < 8; i++) begin
      idx  = reg_idx_e'(i);
      data = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      case (idx)
        REG_COS:    data[15:0] = c.cos_q14;
        REG_SIN:    data[15:0] = c.sin_q14;
        REG_POS_X:  data[11:0] = c.pos_x;
        REG_POS_Y:  data[11:0] = c.pos_y;
        REG_SRC_W:  data[6:0]  = c.src_width;
        REG_SRC_H:  data[6:0]  = c.src_height;
        REG_DEST_W: data[11:0] = c.dest_width;
        REG_DEST_H: data[11:0] = c.dest_height;
        default: ;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CFG_ADDR_W'({idx, 2'b00});
      pwdata  <= data;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_cfg = c;
  endtask

  // aim most renders around the rotation centre so the sprite is actually hit
  task automatic run_phase(cfg_t c, int count);
    int aim_x, aim_y, r;
    drain();
    apply_setting(c);
    steady = ($urandom_range(0, 3) == 0);
    aim_x  = $signed(c.pos_x) + ((c.src_width > SRC_MAX_DIM) ? SRC_MAX_DIM : c.src_width) / 2;
    aim_y  = $signed(c.pos_y) + ((c.src_height > SRC_MAX_DIM) ? SRC_MAX_DIM : c.src_height) / 2;
    repeat (count) begin
      r = $urandom_range(0, 9);
      if (r < 2)
        load_pixel($urandom_range(0, 63), $urandom_range(0, 63), random_color());
      else if (r < 3)
        render_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
      else
        render_pixel(COORD_BITS'(aim_x + $urandom_range(0, 120) - 60),
                     COORD_BITS'(aim_y + $urandom_range(0, 120) - 60));
    end
    phases_run++;
  endtask

  initial begin : sink_stalls
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    cfg_t corner_settings [6];
    // quarter turn, sprite well inside the frame
    corner_settings[0] = '{cos_q14: 16'h0000, sin_q14: 16'h4000, pos_x: 12'd100, pos_y: 12'd200,
                           src_width: 7'd64, src_height: 7'd64,
                           dest_width: 12'd2048, dest_height: 12'd2048};
    // half-unit coefficients hit rounding ties; odd sizes; tight clip
    corner_settings[1] = '{cos_q14: 16'h2000, sin_q14: 16'he000, pos_x: 12'hfec, pos_y: 12'hfec,
                           src_width: 7'd63, src_height: 7'd33,
                           dest_width: 12'd50, dest_height: 12'd40};
    // zero source width, oversized height, zero and maximum clip
    corner_settings[2] = '{cos_q14: 16'hc000, sin_q14: 16'h0000, pos_x: 12'h800, pos_y: 12'h7ff,
                           src_width: 7'd0, src_height: 7'd127,
                           dest_width: 12'd0, dest_height: 12'd4095};
    // single-pixel sprite at the far corner
    corner_settings[3] = '{cos_q14: 16'h4000, sin_q14: 16'h4000, pos_x: 12'h7ff, pos_y: 12'h7ff,
                           src_width: 7'd1, src_height: 7'd1,
                           dest_width: 12'd4095, dest_height: 12'd4095};
    // coefficients beyond unity, oversized source on both axes
    corner_settings[4] = '{cos_q14: 16'h7fff, sin_q14: 16'h8000, pos_x: 12'd10, pos_y: 12'd10,
                           src_width: 7'd127, src_height: 7'd127,
                           dest_width: 12'd2048, dest_height: 12'd2048};
    // half turn, destination one pixel wide
    corner_settings[5] = '{cos_q14: 16'hc000, sin_q14: 16'h0000, pos_x: 12'd0, pos_y: 12'd0,
                           src_width: 7'd64, src_height: 7'd64,
                           dest_width: 12'd1, dest_height: 12'd1};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting maps destination straight onto the source
    load_pixel(5, 7, KEY_BLACK);
    render_pixel(5, 7);
    load_pixel(6, 7, KEY_CLEAR);
    render_pixel(6, 7);
    load_pixel(63, 63, 32'hffff_ffff);
    render_pixel(63, 63);
    load_pixel(0, 0, 32'h0000_0001);
    render_pixel(0, 0);
    load_pixel(63, 0, 32'h8000_0000);
    render_pixel(63, 0);
    load_pixel(0, 63, 32'hff00_0001);
    render_pixel(0, 63);
    render_pixel(64, 0);
    render_pixel(0, 64);
    render_pixel(2047, 2047);
    load_pixel(63, 63, 32'h00ff_ffff);
    render_pixel(63, 63);

    for (int i = 0; i < 6; i++) run_phase(corner_settings[i], 40);
    repeat (8) run_phase(random_setting(), 55);
    run_phase(CFG_RESET, 40);

    drain();
    repeat (20) @(posedge clk_i);
    $display("tb: %0d settings, %0d pixel loads, %0d renders under random stalls",
             phases_run, loads_sent, renders_sent);
    $display("tb: %0d words carried a pixel write, %0d mismatches", write_count, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
